// ----- hw/rtl/brws_pkg.sv -----
`default_nettype none
package brws_pkg;

  localparam int MAX_PARTS = 16;

  localparam int PIX_W    = 40;
  localparam int IDX_W    = 32;
  localparam int PCFG_W   = 5;
  localparam int PART_W   = $clog2(MAX_PARTS + 1);
  localparam int REM_W    = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int SEL_W    = PIX_W + 4;
  localparam int DIVC_W   = $clog2(PIX_W);
  localparam int CIDX_W   = 8;

  localparam int OUT_BITS = PCFG_W + 4 * IDX_W + PIX_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD  = OUT_W - OUT_BITS;

  localparam logic [CIDX_W-1:0] REG_TOTAL_PIXELS  = 8'd0;
  localparam logic [CIDX_W-1:0] REG_PART_COUNT    = 8'd1;
  localparam logic [CIDX_W-1:0] REG_START_BLOCK   = 8'd2;
  localparam logic [CIDX_W-1:0] REG_START_OFFSET  = 8'd3;

  typedef enum logic [3:0] {
    S_ARM,
    S_DIV,
    S_IDLE,
    S_ADD,
    S_CMP,
    S_CUT,
    S_LOOP,
    S_LTEST,
    S_LEMIT,
    S_TERM
  } state_t;

  function automatic logic [PIX_W-1:0] share_size(
    input logic [PIX_W-1:0]  base,
    input logic [REM_W-1:0]  rem,
    input logic [PART_W-1:0] k
  );
    logic [PART_W:0] k_ext;
    logic [PART_W:0] r_ext;
    k_ext = {1'b0, k};
    r_ext = (PART_W + 1)'(rem);
    share_size = base + ((k_ext < r_ext) ? PIX_W'(1) : PIX_W'(0));
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/block_run_work_splitter_top.sv -----
// An input beat that cuts no block passes S_ADD, S_CMP and S_TERM; cutting a block adds
// S_CUT, S_LOOP and S_LTEST, and S_LEMIT, S_LOOP and S_LTEST for each further share it
// spills into; a full output register stalls. Not ready while an item is in work.
// A single compare/subtract sequencer does all the work.
// Reset and every write to one of the four configuration registers rearm the run, then
// a restoring division of total_pixels by the part count; input waits until it ends.
`default_nettype none
module block_run_work_splitter_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [brws_pkg::CIDX_W-1:0]   cfg_index,
  input  wire logic [brws_pkg::PIX_W-1:0]    cfg_data,
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  input  wire logic [brws_pkg::IDX_W-1:0]    s_axis_tdata,  // blk_pixels
  input  wire logic                          s_axis_tlast,  // is_last_block
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // part_index, first_block_index, pixel_start, block_count, first_block_offset,
  // last_block_end, zero pad
  output      logic [brws_pkg::OUT_W-1:0]    m_axis_tdata,
  output      logic                          m_axis_tlast   // is_final
);
  import brws_pkg::*;

  logic [PIX_W-1:0]  total_pixels;
  logic [PCFG_W-1:0] part_count;
  logic [IDX_W-1:0]  start_block_index;
  logic [IDX_W-1:0]  start_offset;

  state_t state, state_next;

  logic [PART_W-1:0] p_r, p_r_next;
  logic [PIX_W-1:0]  share_base, share_base_next;
  logic [REM_W-1:0]  share_remainder, share_remainder_next;
  logic [DIVC_W-1:0] div_cnt, div_cnt_next;
  logic [SEL_W-1:0]  sel, sel_next;
  logic [PART_W-1:0] share_counter, share_counter_next;
  logic [IDX_W-1:0]  run_start_block, run_start_block_next;
  logic [PIX_W-1:0]  pixel_cursor, pixel_cursor_next;
  logic [IDX_W-1:0]  split_offset, split_offset_next;
  logic [IDX_W-1:0]  block_counter, block_counter_next;
  logic              finished, finished_next;
  logic [IDX_W-1:0]  cur_size, cur_size_next;
  logic              cur_last, cur_last_next;
  logic [IDX_W-1:0]  cur_idx, cur_idx_next;
  logic [IDX_W-1:0]  cur_cnt, cur_cnt_next;
  logic [PIX_W-1:0]  s_reg, s_reg_next;

  logic              out_valid, out_valid_next;
  logic [PCFG_W-1:0] o_part, o_part_next;
  logic [IDX_W-1:0]  o_first, o_first_next;
  logic [PIX_W-1:0]  o_pix, o_pix_next;
  logic [IDX_W-1:0]  o_count, o_count_next;
  logic [IDX_W-1:0]  o_off, o_off_next;
  logic [IDX_W-1:0]  o_end, o_end_next;
  logic              o_fin, o_fin_next;

  logic              out_free;
  logic [REM_W:0]    div_t;
  logic              div_ge;
  logic [SEL_W-1:0]  s_ext;
  logic [SEL_W-1:0]  mag;
  logic [IDX_W-1:0]  cut;
  logic              cfg_hit;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = o_fin;
  assign m_axis_tdata  = {OUT_PAD'(0), o_end, o_off, o_count, o_pix, o_first, o_part};
  assign out_free      = !out_valid || m_axis_tready;

  assign div_t  = {share_remainder, share_base[PIX_W-1]};
  assign div_ge = (div_t >= (REM_W + 1)'(p_r));
  assign s_ext  = SEL_W'(s_reg);
  assign mag    = sel[SEL_W-1] ? (SEL_W'(0) - sel) : sel;
  assign cut    = cur_size - sel[IDX_W-1:0];
  assign cfg_hit = cfg_valid && (cfg_index == REG_TOTAL_PIXELS ||
                   cfg_index == REG_PART_COUNT || cfg_index == REG_START_BLOCK ||
                   cfg_index == REG_START_OFFSET);

  always_ff @(posedge clk) begin
    if (rst) begin
      total_pixels      <= PIX_W'(1);
      part_count        <= PCFG_W'(1);
      start_block_index <= '0;
      start_offset      <= '0;
      state             <= S_ARM;
      out_valid         <= 1'b0;
      finished          <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_TOTAL_PIXELS: total_pixels      <= cfg_data;
          REG_PART_COUNT:   part_count        <= cfg_data[PCFG_W-1:0];
          REG_START_BLOCK:  start_block_index <= cfg_data[IDX_W-1:0];
          REG_START_OFFSET: start_offset      <= cfg_data[IDX_W-1:0];
          default: ;
        endcase
      end
      state     <= state_next;
      out_valid <= out_valid_next;
      finished  <= finished_next;
    end
  end

  always_ff @(posedge clk) begin
    p_r             <= p_r_next;
    share_base      <= share_base_next;
    share_remainder <= share_remainder_next;
    div_cnt         <= div_cnt_next;
    sel             <= sel_next;
    share_counter   <= share_counter_next;
    run_start_block <= run_start_block_next;
    pixel_cursor    <= pixel_cursor_next;
    split_offset    <= split_offset_next;
    block_counter   <= block_counter_next;
    cur_size        <= cur_size_next;
    cur_last        <= cur_last_next;
    cur_idx         <= cur_idx_next;
    cur_cnt         <= cur_cnt_next;
    s_reg           <= s_reg_next;
    o_part          <= o_part_next;
    o_first         <= o_first_next;
    o_pix           <= o_pix_next;
    o_count         <= o_count_next;
    o_off           <= o_off_next;
    o_end           <= o_end_next;
    o_fin           <= o_fin_next;
  end

  always_comb begin
    state_next           = state;
    p_r_next             = p_r;
    share_base_next      = share_base;
    share_remainder_next = share_remainder;
    div_cnt_next         = div_cnt;
    sel_next             = sel;
    share_counter_next   = share_counter;
    run_start_block_next = run_start_block;
    pixel_cursor_next    = pixel_cursor;
    split_offset_next    = split_offset;
    block_counter_next   = block_counter;
    finished_next        = finished;
    cur_size_next        = cur_size;
    cur_last_next        = cur_last;
    cur_idx_next         = cur_idx;
    cur_cnt_next         = cur_cnt;
    s_reg_next           = s_reg;
    out_valid_next       = out_valid && !m_axis_tready;
    o_part_next          = o_part;
    o_first_next         = o_first;
    o_pix_next           = o_pix;
    o_count_next         = o_count;
    o_off_next           = o_off;
    o_end_next           = o_end;
    o_fin_next           = o_fin;

    unique case (state)
      S_ARM: begin
        if (part_count == '0) begin
          p_r_next = PART_W'(1);
        end else if (32'(part_count) > MAX_PARTS) begin
          p_r_next = PART_W'(MAX_PARTS);
        end else begin
          p_r_next = PART_W'(part_count);
        end
        share_base_next      = total_pixels;
        share_remainder_next = '0;
        div_cnt_next         = '0;
        sel_next             = SEL_W'(0) - SEL_W'(start_offset);
        share_counter_next   = '0;
        run_start_block_next = start_block_index;
        pixel_cursor_next    = '0;
        split_offset_next    = start_offset;
        block_counter_next   = start_block_index;
        finished_next        = 1'b0;
        state_next           = S_DIV;
      end
      S_DIV: begin
        share_base_next      = {share_base[PIX_W-2:0], div_ge};
        share_remainder_next = div_ge ? REM_W'(div_t - (REM_W + 1)'(p_r))
                                      : div_t[REM_W-1:0];
        div_cnt_next         = div_cnt + 1'b1;
        if (div_cnt == DIVC_W'(PIX_W - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cur_size_next = s_axis_tdata;
          cur_last_next = s_axis_tlast;
          cur_idx_next  = block_counter;
          if (!finished) begin
            block_counter_next = block_counter + 1'b1;
            state_next         = S_ADD;
          end
        end
      end
      S_ADD: begin
        sel_next     = sel + SEL_W'(cur_size);
        s_reg_next   = share_size(share_base, share_remainder, share_counter);
        cur_cnt_next = cur_idx - run_start_block + 1'b1;
        state_next   = S_CMP;
      end
      S_CMP: begin
        if (sel == s_ext) begin
          if (out_free) begin
            out_valid_next       = 1'b1;
            o_part_next          = PCFG_W'(share_counter);
            o_first_next         = run_start_block;
            o_pix_next           = pixel_cursor;
            o_count_next         = cur_cnt;
            o_off_next           = split_offset;
            o_end_next           = (cur_cnt <= IDX_W'(1)) ?
                                   (s_reg[IDX_W-1:0] + split_offset) : cur_size;
            o_fin_next           = 1'b0;
            share_counter_next   = share_counter + 1'b1;
            run_start_block_next = cur_idx + 1'b1;
            pixel_cursor_next    = pixel_cursor + s_reg;
            sel_next             = '0;
            split_offset_next    = '0;
            state_next           = S_TERM;
          end
        end else if (mag > s_ext) begin
          sel_next   = sel - s_ext;
          state_next = S_CUT;
        end else begin
          state_next = S_TERM;
        end
      end
      S_CUT: begin
        if (out_free) begin
          out_valid_next       = 1'b1;
          o_part_next          = PCFG_W'(share_counter);
          o_first_next         = run_start_block;
          o_pix_next           = pixel_cursor;
          o_count_next         = cur_cnt;
          o_off_next           = split_offset;
          o_end_next           = cut;
          o_fin_next           = 1'b0;
          share_counter_next   = share_counter + 1'b1;
          run_start_block_next = cur_idx;
          pixel_cursor_next    = pixel_cursor + s_reg;
          split_offset_next    = cut;
          state_next           = S_LOOP;
        end
      end
      S_LOOP: begin
        s_reg_next = share_size(share_base, share_remainder, share_counter);
        state_next = S_LTEST;
      end
      S_LTEST: begin
        if (share_counter < p_r && (sel[SEL_W-1] || sel >= s_ext)) begin
          sel_next   = sel - s_ext;
          state_next = S_LEMIT;
        end else begin
          state_next = S_TERM;
        end
      end
      S_LEMIT: begin
        if (out_free) begin
          out_valid_next     = 1'b1;
          o_part_next        = PCFG_W'(share_counter);
          o_first_next       = run_start_block;
          o_pix_next         = pixel_cursor;
          o_count_next       = IDX_W'(1);
          o_off_next         = split_offset;
          o_end_next         = cut;
          o_fin_next         = 1'b0;
          share_counter_next = share_counter + 1'b1;
          pixel_cursor_next  = pixel_cursor + s_reg;
          if (sel == '0) begin
            run_start_block_next = run_start_block + 1'b1;
            split_offset_next    = '0;
          end else begin
            split_offset_next    = cut;
          end
          state_next = S_LOOP;
        end
      end
      S_TERM: begin
        if (share_counter >= p_r || cur_last) begin
          if (out_free) begin
            out_valid_next = 1'b1;
            o_part_next    = PCFG_W'(p_r);
            o_first_next   = run_start_block;
            o_pix_next     = pixel_cursor;
            o_count_next   = run_start_block;
            o_off_next     = split_offset;
            o_end_next     = '0;
            o_fin_next     = 1'b1;
            finished_next  = 1'b1;
            state_next     = S_IDLE;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_ARM;
    endcase

    if (cfg_hit) begin
      state_next = S_ARM;
    end
  end

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
  import brws_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RST_CYCLES    = 2;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 100;
  localparam int MAX_REPORTS   = 200;
  localparam longint CYCLE_LIMIT = 1000000;

  localparam logic [CIDX_W-1:0] REG_NONE = CIDX_W'(9);
  localparam logic [63:0] M32 = 64'hFFFF_FFFF;
  localparam logic [63:0] M40 = 64'hFF_FFFF_FFFF;

  // tdata field positions
  localparam int FBI_LO = PCFG_W;
  localparam int PIX_LO = FBI_LO + IDX_W;
  localparam int CNT_LO = PIX_LO + PIX_W;
  localparam int OFF_LO = CNT_LO + IDX_W;
  localparam int END_LO = OFF_LO + IDX_W;

  typedef struct packed {
    logic [PCFG_W-1:0] part;
    logic [IDX_W-1:0]  first_blk;
    logic [PIX_W-1:0]  pix_start;
    logic [IDX_W-1:0]  blk_cnt;
    logic [IDX_W-1:0]  first_off;
    logic [IDX_W-1:0]  last_end;
    logic              fin;
  } desc_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [PIX_W-1:0]  cfg_data = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IDX_W-1:0]  s_axis_tdata = '0;
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              m_axis_tlast;

  // split predictor: register copies and run state
  logic [63:0] set_total, set_parts, set_first_blk, set_first_off;
  logic [63:0] shr_base, shr_rem, fill_level, shr_idx;
  logic [63:0] run_block, pix_pos, cut_off, next_block;
  bit          run_done;

  desc_t  desc_q[$];
  int     mismatches = 0;
  int     desc_seen = 0;
  int     live_items = 0;
  int     rx_wait = 0;
  longint cycle_count = 0;
  bit     tx_calm = 1'b0;
  bit     rx_calm = 1'b0;
  logic   rx_hold = 1'b0;
  event   hold_start;

  block_run_work_splitter_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [63:0] parts_in_use();
    if (set_parts < 1) return 64'd1;
    if (set_parts > MAX_PARTS) return 64'(MAX_PARTS);
    return set_parts;
  endfunction

  function automatic void rearm_split();
    logic [63:0] p;
    p = parts_in_use();
    shr_base   = set_total / p;
    shr_rem    = set_total % p;
    fill_level = 64'd0 - set_first_off;
    shr_idx    = 64'd0;
    run_block  = set_first_blk;
    pix_pos    = 64'd0;
    cut_off    = set_first_off;
    next_block = set_first_blk;
    run_done   = 1'b0;
  endfunction

  function automatic void apply_reg(input logic [CIDX_W-1:0] idx, input logic [PIX_W-1:0] value);
    case (idx)
      REG_TOTAL_PIXELS: set_total = 64'(value);
      REG_PART_COUNT:   set_parts = 64'(value[PCFG_W-1:0]);
      REG_START_BLOCK:  set_first_blk = 64'(value[IDX_W-1:0]);
      REG_START_OFFSET: set_first_off = 64'(value[IDX_W-1:0]);
      default: return;
    endcase
    rearm_split();
  endfunction

  function automatic logic [63:0] share_len(input logic [63:0] k);
    return shr_base + ((k < shr_rem) ? 64'd1 : 64'd0);
  endfunction

  function automatic void push_desc(input logic [63:0] part, input logic [63:0] first,
                                    input logic [63:0] pix, input logic [63:0] cnt,
                                    input logic [63:0] off, input logic [63:0] stop,
                                    input bit fin);
    desc_t d;
    d.part      = part[PCFG_W-1:0];
    d.first_blk = first[IDX_W-1:0];
    d.pix_start = pix[PIX_W-1:0];
    d.blk_cnt   = cnt[IDX_W-1:0];
    d.first_off = off[IDX_W-1:0];
    d.last_end  = stop[IDX_W-1:0];
    d.fin       = fin;
    desc_q.push_back(d);
  endfunction

  // fill level is signed; a start offset past the first block leaves it negative
  function automatic void predict_block(input logic [IDX_W-1:0] size32, input bit last_blk);
    logic [63:0] p, size, idx, s, mag, cnt, over, cut, sk;
    if (run_done) return;
    p = parts_in_use();
    size = 64'(size32);
    idx = next_block;
    next_block = (next_block + 1) & M32;
    s = share_len(shr_idx);
    fill_level = fill_level + size;
    mag = fill_level[63] ? (64'd0 - fill_level) : fill_level;
    if (fill_level == s) begin
      cnt = idx - run_block + 1;
      push_desc(shr_idx, run_block, pix_pos, cnt, cut_off,
                ((cnt & M32) <= 1) ? s + cut_off : size, 1'b0);
      shr_idx    = shr_idx + 1;
      run_block  = (idx + 1) & M32;
      pix_pos    = (pix_pos + fill_level) & M40;
      fill_level = 64'd0;
      cut_off    = 64'd0;
    end else if (mag > s) begin
      cnt  = idx - run_block + 1;
      over = fill_level - s;
      cut  = size - over;
      push_desc(shr_idx, run_block, pix_pos, cnt, cut_off, cut, 1'b0);
      shr_idx    = shr_idx + 1;
      run_block  = idx;
      pix_pos    = (pix_pos + s) & M40;
      fill_level = over;
      cut_off    = cut;
      while (shr_idx < p && over >= share_len(shr_idx)) begin
        sk   = share_len(shr_idx);
        over = fill_level - sk;
        cut  = size - over;
        push_desc(shr_idx, run_block, pix_pos, 64'd1, cut_off, cut, 1'b0);
        shr_idx    = shr_idx + 1;
        pix_pos    = (pix_pos + sk) & M40;
        cut_off    = cut;
        fill_level = over;
        if (over == 0) begin
          run_block = (run_block + 1) & M32;
          cut_off   = 64'd0;
        end
      end
    end
    if (shr_idx >= p || last_blk) begin
      push_desc(p, run_block, pix_pos, run_block, cut_off, 64'd0, 1'b1);
      run_done = 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < MAX_REPORTS)
      $display("MISMATCH beat %0d %s: got 0x%0h want 0x%0h (cycle %0d)",
               desc_seen, what, got, want, cycle_count);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk) begin
    desc_t got;
    desc_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.part      = m_axis_tdata[PCFG_W-1:0];
      got.first_blk = m_axis_tdata[FBI_LO +: IDX_W];
      got.pix_start = m_axis_tdata[PIX_LO +: PIX_W];
      got.blk_cnt   = m_axis_tdata[CNT_LO +: IDX_W];
      got.first_off = m_axis_tdata[OFF_LO +: IDX_W];
      got.last_end  = m_axis_tdata[END_LO +: IDX_W];
      got.fin       = m_axis_tlast;
      if (m_axis_tdata[OUT_W-1:OUT_BITS] != '0)
        report_mismatch("pad", 64'(m_axis_tdata[OUT_W-1:OUT_BITS]), 64'd0);
      if (desc_q.size() == 0) begin
        report_mismatch("unexpected descriptor, part", 64'(got.part), 64'd0);
      end else begin
        want = desc_q.pop_front();
        if (got.part != want.part)
          report_mismatch("part_index", 64'(got.part), 64'(want.part));
        if (got.first_blk != want.first_blk)
          report_mismatch("first_block_index", 64'(got.first_blk), 64'(want.first_blk));
        if (got.pix_start != want.pix_start)
          report_mismatch("pixel_start", 64'(got.pix_start), 64'(want.pix_start));
        if (got.blk_cnt != want.blk_cnt)
          report_mismatch("block_count", 64'(got.blk_cnt), 64'(want.blk_cnt));
        if (got.first_off != want.first_off)
          report_mismatch("first_block_offset", 64'(got.first_off), 64'(want.first_off));
        if (got.last_end != want.last_end)
          report_mismatch("last_block_end", 64'(got.last_end), 64'(want.last_end));
        if (got.fin != want.fin)
          report_mismatch("is_final", 64'(got.fin), 64'(want.fin));
      end
      desc_seen++;
    end
  end

  // output ready with random per-beat gaps
  always @(posedge clk) begin
    int gap;
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_wait <= 0;
    end else if (rx_hold) begin
      m_axis_tready <= 1'b0;
    end else if (m_axis_tready && m_axis_tvalid) begin
      gap = rx_calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        rx_wait <= gap - 1;
      end
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // long output stall
  always begin
    @(hold_start);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic send_block(input logic [IDX_W-1:0] size, input bit last_blk);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= size;
    s_axis_tlast  <= last_blk;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (!run_done) live_items++;
    predict_block(size, last_blk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (desc_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [PIX_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    apply_reg(idx, value);
  endtask

  task automatic setup_run(input logic [PIX_W-1:0] total, input logic [PIX_W-1:0] parts,
                           input logic [PIX_W-1:0] first_blk, input logic [PIX_W-1:0] off);
    write_reg(REG_TOTAL_PIXELS, total);
    write_reg(REG_PART_COUNT, parts);
    write_reg(REG_START_BLOCK, first_blk);
    write_reg(REG_START_OFFSET, off);
  endtask

  task automatic test_reset_defaults();
    send_block(32'd1, 1'b0);
    send_block(32'd5, 1'b0);   // after terminator: dropped
  endtask

  task automatic test_exact_and_spill();
    setup_run(40'd100, 40'd4, 40'd10, 40'd0);
    send_block(32'd25, 1'b0);
    send_block(32'd10, 1'b0);
    send_block(32'd15, 1'b0);
    send_block(32'd60, 1'b0);
  endtask

  task automatic test_part_limits();
    setup_run(40'd7, 40'd0, 40'd0, 40'd0);
    send_block(32'd7, 1'b0);
    setup_run(40'd40, 40'd31, 40'd0, 40'd0);
    send_block(32'd40, 1'b0);
  endtask

  task automatic test_empty_shares();
    setup_run(40'd3, 40'd8, 40'd0, 40'd0);
    send_block(32'd0, 1'b0);
    send_block(32'd3, 1'b0);
  endtask

  task automatic test_start_offset();
    setup_run(40'd20, 40'd2, 40'd0, 40'd5);
    send_block(32'd15, 1'b0);
    send_block(32'd20, 1'b0);
    // offset past the first block: negative fill wraps the overhang
    setup_run(40'd20, 40'd2, 40'd0, 40'd100);
    send_block(32'd10, 1'b0);
  endtask

  task automatic test_index_wrap();
    setup_run(40'd30, 40'd3, 40'hFFFF_FFFE, 40'd0);
    send_block(32'd4, 1'b0);
    send_block(32'd4, 1'b0);
    send_block(32'd4, 1'b0);
    send_block(32'd4, 1'b0);
    send_block(32'd14, 1'b0);
  endtask

  task automatic test_early_last();
    setup_run(40'd1000, 40'd4, 40'd7, 40'd3);
    send_block(32'd100, 1'b1);
    send_block(32'd50, 1'b0);
  endtask

  task automatic test_extremes();
    setup_run(40'hFF_FFFF_FFFF, 40'd16, 40'hFFFF_FFFF, 40'hFFFF_FFFF);
    send_block(32'hFFFF_FFFF, 1'b0);
    write_reg(REG_NONE, '1);   // not a register: run keeps going
    send_block(32'd0, 1'b1);
    setup_run(40'hFF_FFFF_FFFF, 40'd1, 40'd0, 40'd0);
    send_block(32'hFFFF_FFFF, 1'b1);
  endtask

  task automatic test_output_backpressure();
    setup_run(40'd128, 40'd16, 40'd0, 40'd0);
    tx_calm = 1'b1;
    -> hold_start;
    repeat (20) send_block(32'd8, 1'b0);
    tx_calm = 1'b0;
  endtask

  task automatic test_random_runs();
    int          mode, pick, n, base;
    logic [63:0] total;
    logic [31:0] size, off;
    bit          last_blk;
    base = live_items;
    while (live_items - base < RANDOM_ITEMS) begin
      mode    = $urandom_range(0, 7);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if (mode == 0)
        total = {24'd0, 8'($urandom_range(0, 255)), 32'($urandom)};
      else
        total = 64'($urandom_range(1, 3000));
      if (total == 0) total = 64'd1;
      write_reg(REG_TOTAL_PIXELS, total[PIX_W-1:0]);
      if ($urandom_range(0, 3) != 0) begin
        pick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
        write_reg(REG_PART_COUNT,
                  {35'(($urandom_range(0, 7) == 0) ? $urandom : 0), 5'(pick)});
      end
      if ($urandom_range(0, 1) != 0)
        write_reg(REG_START_BLOCK, {8'($urandom), 32'($urandom)});
      if ($urandom_range(0, 1) != 0) begin
        pick = $urandom_range(0, 9);
        if (pick == 0)      off = $urandom;
        else if (pick < 4)  off = $urandom_range(0, 40);
        else                off = 32'd0;
        write_reg(REG_START_OFFSET, {8'($urandom), off});
      end
      n = 0;
      while (!run_done && n < 48) begin
        pick = $urandom_range(0, 15);
        if (mode == 0)
          size = (pick < 2) ? 32'd0 : $urandom;
        else if (pick == 0)
          size = 32'd0;
        else if (pick == 1)
          size = $urandom;
        else if (pick == 2)
          size = $urandom_range(0, 32'(set_total));
        else
          size = $urandom_range(1, 32'(2 * shr_base + 2));
        last_blk = ($urandom_range(0, 24) == 0);
        send_block(size, last_blk);
        n++;
      end
      if (run_done && $urandom_range(0, 2) == 0)
        send_block($urandom, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    set_total     = 64'd1;
    set_parts     = 64'd1;
    set_first_blk = 64'd0;
    set_first_off = 64'd0;
    rearm_split();
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_exact_and_spill();
    test_part_limits();
    test_empty_shares();
    test_start_offset();
    test_index_wrap();
    test_early_last();
    test_extremes();
    test_output_backpressure();
    test_random_runs();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && desc_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
